// ----- hdl/lswd_pkg.sv -----
package lswd_pkg;

   localparam int unsigned TIME_BITS    = 12;
   localparam int unsigned ELAPSED_BITS = TIME_BITS + 1;
   localparam int unsigned COUNT_BITS   = TIME_BITS - 3;

   localparam logic [TIME_BITS-1:0] MIN_DEBOUNCE      = TIME_BITS'(50);
   localparam logic [TIME_BITS-1:0] FALLBACK_INTERVAL = TIME_BITS'(10);

   localparam logic [TIME_BITS-1:0] DEBOUNCE_RESET = TIME_BITS'(150);
   localparam logic [TIME_BITS-1:0] INTERVAL_RESET = TIME_BITS'(50);

   typedef enum logic {
      KIND_TICK    = 1'b0,
      KIND_TRIGGER = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      FORCE_LOW   = 2'd0,
      FORCE_HIGH  = 2'd1,
      FORCE_NONE  = 2'd2,
      FORCE_NONE3 = 2'd3
   } force_mode_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_INTERVAL = 2'd1,
      CSR_FORCE    = 2'd2,
      CSR_ENABLE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic kind;
      logic pin_level;
   } req_type;

   typedef struct packed {
      logic lid_report;
      logic was_forced;
   } rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] debounce_ms;
      logic [TIME_BITS-1:0] interval_ms;
      logic [1:0]           force_mode;
      logic                 sensor_enable;
   } cfg_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } result_type;

endpackage

// ----- hdl/lswd_window.sv -----
module lswd_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  lswd_pkg::req_type   item,
   input  lswd_pkg::cfg_type   cfg,
   output lswd_pkg::result_type result
);

   logic                                  pin_status_ff, pin_status_in;
   logic                                  saved_status_ff, saved_status_in;
   logic                                  busy_ff, busy_in;
   logic [lswd_pkg::TIME_BITS-1:0]        interval_count_ff, interval_count_in;
   logic [lswd_pkg::ELAPSED_BITS-1:0]     elapsed_ff, elapsed_in;
   logic [lswd_pkg::COUNT_BITS-1:0]       sample_total_ff, sample_total_in;
   logic [lswd_pkg::COUNT_BITS-1:0]       low_total_ff, low_total_in;

   logic [lswd_pkg::TIME_BITS-1:0]        eff_debounce;
   logic [lswd_pkg::TIME_BITS-1:0]        eff_interval;
   logic [lswd_pkg::ELAPSED_BITS-1:0]     count_next;
   logic                                  sample_now;
   logic [lswd_pkg::ELAPSED_BITS-1:0]     elapsed_next;
   logic [lswd_pkg::ELAPSED_BITS:0]       horizon;
   logic                                  close_now;
   logic [lswd_pkg::COUNT_BITS-1:0]       low_next;
   logic [lswd_pkg::COUNT_BITS-1:0]       sample_next;
   logic                                  mixed;
   logic                                  forced;

   assign eff_debounce = (cfg.debounce_ms < lswd_pkg::MIN_DEBOUNCE) ?
                         lswd_pkg::MIN_DEBOUNCE : cfg.debounce_ms;
   // Interval range check uses the raw debounce value, not the clamped one.
   assign eff_interval = (cfg.interval_ms < lswd_pkg::FALLBACK_INTERVAL ||
                          cfg.interval_ms > cfg.debounce_ms) ?
                         lswd_pkg::FALLBACK_INTERVAL : cfg.interval_ms;

   assign count_next   = {1'b0, interval_count_ff} + lswd_pkg::ELAPSED_BITS'(1);
   assign sample_now   = count_next >= {1'b0, eff_interval};
   assign elapsed_next = elapsed_ff + {1'b0, eff_interval};
   assign horizon      = {1'b0, elapsed_next} + {2'b00, eff_interval};
   assign close_now    = horizon > {2'b00, eff_debounce};
   assign low_next     = low_total_ff +
                         {{(lswd_pkg::COUNT_BITS-1){1'b0}}, ~item.pin_level};
   assign sample_next  = sample_total_ff + lswd_pkg::COUNT_BITS'(1);
   assign mixed        = (low_next != '0) && (low_next < sample_next);
   assign forced       = (cfg.force_mode == lswd_pkg::FORCE_LOW) ||
                         (cfg.force_mode == lswd_pkg::FORCE_HIGH);

   always_comb begin
      pin_status_in     = pin_status_ff;
      saved_status_in   = saved_status_ff;
      busy_in           = busy_ff;
      interval_count_in = interval_count_ff;
      elapsed_in        = elapsed_ff;
      sample_total_in   = sample_total_ff;
      low_total_in      = low_total_ff;
      result            = '0;
      if (step) begin
         if (item.kind == lswd_pkg::KIND_TRIGGER) begin
            if (!busy_ff) begin
               if (forced) begin
                  result.valid          = 1'b1;
                  result.rsp.lid_report = cfg.force_mode[0];
                  result.rsp.was_forced = 1'b1;
               end else if (cfg.sensor_enable) begin
                  // open window
                  saved_status_in   = pin_status_ff;
                  busy_in           = 1'b1;
                  interval_count_in = '0;
                  elapsed_in        = '0;
                  sample_total_in   = '0;
                  low_total_in      = '0;
               end
            end
         end else if (busy_ff) begin
            if (!sample_now) begin
               interval_count_in = count_next[lswd_pkg::TIME_BITS-1:0];
            end else begin
               interval_count_in = '0;
               elapsed_in        = elapsed_next;
               pin_status_in     = item.pin_level;
               low_total_in      = low_next;
               sample_total_in   = sample_next;
               if (close_now) begin
                  busy_in = 1'b0;
                  if (mixed) begin
                     // restore status, drop the window
                     pin_status_in = saved_status_ff;
                  end else begin
                     result.valid          = 1'b1;
                     result.rsp.lid_report = ~item.pin_level;
                     result.rsp.was_forced = 1'b0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_status_ff     <= 1'b0;
         saved_status_ff   <= 1'b0;
         busy_ff           <= 1'b0;
         interval_count_ff <= '0;
         elapsed_ff        <= '0;
         sample_total_ff   <= '0;
         low_total_ff      <= '0;
      end else begin
         pin_status_ff     <= pin_status_in;
         saved_status_ff   <= saved_status_in;
         busy_ff           <= busy_in;
         interval_count_ff <= interval_count_in;
         elapsed_ff        <= elapsed_in;
         sample_total_ff   <= sample_total_in;
         low_total_ff      <= low_total_in;
      end
   end

`ifndef SYNTHESIS
   a_close_on_tick: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(step) && ($past(item.kind) == lswd_pkg::KIND_TICK))
      else $error("window closed without a tick");

   a_normal_on_close: assert property (@(posedge clock) disable iff (reset)
      (result.valid && !result.rsp.was_forced) |-> (busy_ff && !busy_in))
      else $error("normal report outside window close");

   a_forced_idle: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.rsp.was_forced) |-> (!busy_ff && !busy_in))
      else $error("forced report during a window");
`endif

endmodule

// ----- hdl/lswd_rsp_queue.sv -----
module lswd_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lswd_pkg::rsp_type push_data,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lswd_pkg::rsp_type rsp_data
);

   lswd_pkg::rsp_type entry_ff [2];
   logic [1:0]        count_ff, count_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              pop;

   assign room      = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      count_in  = count_ff + 2'(push) - 2'(pop);
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !room))
      else $error("push into full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (rd_ptr_ff != wr_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

// ----- hdl/lid_switch_window_debouncer.sv -----
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_data (kind, pin_level)
// rsp_      out        rsp_valid/rsp_stall  rsp_data (lid_report, was_forced)
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One item per cycle while the result queue has room; an item is registered,
// processed once the queue has room; its result, if any, is visible next cycle.
// Synchronous active-high reset restores register defaults and closes any window.
// A two-entry result queue absorbs rsp_stall; req_stall rises only once it is full.
// csr_ready is always high; write registers only while no item is in flight.
module lid_switch_window_debouncer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lswd_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lswd_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  lswd_pkg::csr_index_type       csr_index,
   input  logic [lswd_pkg::TIME_BITS-1:0] csr_wdata
);

   lswd_pkg::cfg_type    cfg_ff, cfg_in;
   logic                 in_valid_ff, in_valid_in;
   lswd_pkg::req_type    in_data_ff;
   logic                 room;
   logic                 advance;
   logic                 take;
   lswd_pkg::result_type result;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lswd_pkg::CSR_DEBOUNCE: cfg_in.debounce_ms   = csr_wdata;
            lswd_pkg::CSR_INTERVAL: cfg_in.interval_ms   = csr_wdata;
            lswd_pkg::CSR_FORCE:    cfg_in.force_mode    = csr_wdata[1:0];
            lswd_pkg::CSR_ENABLE:   cfg_in.sensor_enable = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= lswd_pkg::DEBOUNCE_RESET;
         cfg_ff.interval_ms   <= lswd_pkg::INTERVAL_RESET;
         cfg_ff.force_mode    <= lswd_pkg::FORCE_NONE;
         cfg_ff.sensor_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // hold the input item while the result queue is full
   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign take      = req_valid && !req_stall;

   always_comb begin
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
   end

   lswd_window u_window (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   lswd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result.valid),
      .push_data (result.rsp),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall without a held item");

   a_held_item_stable: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("held input item lost or changed");

   a_result_from_step: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> advance)
      else $error("result without a processed item");
`endif

endmodule
